// ===== src/ipl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the integer literal parser.
// Used by the controller, the datapath and the top level; depends on nothing.
package ipl_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 12;
  localparam int PROD_WIDTH  = VALUE_WIDTH + 5;
  localparam int OUT_DATA_W  = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [5:0] NOT_DIGIT = 6'd36;
  localparam logic [5:0] LETTER_BASE = 6'd10;

  typedef enum logic [4:0] {
    PH_SIGN   = 5'b00001,
    PH_RADIX  = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    RDX_BIN,
    RDX_OCT,
    RDX_DEC,
    RDX_HEX
  } radix_t;

  typedef enum logic [1:0] {
    RS_KEEP,
    RS_DEC,
    RS_OCT,
    RS_PREFIX
  } radix_op_t;

  typedef enum logic [1:0] {
    DC_KEEP,
    DC_ONE,
    DC_CLEAR,
    DC_INC
  } dcnt_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic      step;
    logic      restart;
    logic      set_neg;
    logic      accept;
    dcnt_op_t  dcnt_op;
    radix_op_t radix_op;
    logic      digit_upd;
    logic      emit;
    status_t   emit_status;
  } ipl_cmd_t;

  typedef struct packed {
    logic is_minus;
    logic is_plus;
    logic is_zero;
    logic is_prefix;
    logic digit_ok;
    logic overflow;
    logic dcnt_zero;
  } ipl_sts_t;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    case (c) inside
      [CH_0:CH_9]:   t = c - CH_0;
      [CH_LA:CH_LZ]: t = c - CH_LA + {2'b00, LETTER_BASE};
      [CH_UA:CH_UZ]: t = c - CH_UA + {2'b00, LETTER_BASE};
      default:       t = {2'b00, NOT_DIGIT};
    endcase
    return t[5:0];
  endfunction

  function automatic logic [4:0] radix_value(input radix_t r);
    logic [4:0] v;
    case (r)
      RDX_BIN: v = 5'd2;
      RDX_OCT: v = 5'd8;
      RDX_DEC: v = 5'd10;
      RDX_HEX: v = 5'd16;
      default: v = 5'd10;
    endcase
    return v;
  endfunction

endpackage

// ===== src/ipl_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the integer literal parser: character decode, accumulator,
// counters, overflow check and result register. Depends on ipl_pkg.
module ipl_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [7:0]                          char_code,
  input  ipl_pkg::ipl_cmd_t                   cmd,
  output ipl_pkg::ipl_sts_t                   sts,
  output logic signed [ipl_pkg::VALUE_WIDTH-1:0] res_value,
  output logic [ipl_pkg::COUNT_WIDTH-1:0]     res_count,
  output logic [1:0]                          res_status
);
  import ipl_pkg::*;

  logic                   neg_r, neg_nxt, neg_eff;
  radix_t                 radix_r, radix_nxt, radix_eff, radix_cur, prefix_radix;
  logic [VALUE_WIDTH-1:0] run_r, run_nxt, run_eff;
  logic [COUNT_WIDTH-1:0] dcnt_r, dcnt_nxt, dcnt_eff;
  logic [COUNT_WIDTH-1:0] ccnt_r, ccnt_nxt, ccnt_eff;
  logic [7:0]             lower;
  logic [5:0]             digit;
  logic [4:0]             rv;
  logic [PROD_WIDTH-1:0]  run_ext, prod, sum, limit;
  logic                   is_prefix;

  logic signed [VALUE_WIDTH-1:0] value_r;
  logic [COUNT_WIDTH-1:0]        count_r;
  logic [1:0]                    status_r;

  assign neg_eff   = cmd.restart ? 1'b0 : neg_r;
  assign radix_eff = cmd.restart ? RDX_DEC : radix_r;
  assign run_eff   = cmd.restart ? '0 : run_r;
  assign dcnt_eff  = cmd.restart ? '0 : dcnt_r;
  assign ccnt_eff  = cmd.restart ? '0 : ccnt_r;

  assign lower = ((char_code >= CH_UA) && (char_code <= CH_UZ)) ? (char_code | CASE_BIT)
                                                                 : char_code;

  always_comb begin
    is_prefix    = 1'b1;
    prefix_radix = RDX_DEC;
    case (lower)
      CH_LX:   prefix_radix = RDX_HEX;
      CH_LB:   prefix_radix = RDX_BIN;
      CH_LO:   prefix_radix = RDX_OCT;
      CH_LD:   prefix_radix = RDX_DEC;
      default: is_prefix = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.radix_op)
      RS_KEEP:   radix_cur = radix_eff;
      RS_DEC:    radix_cur = RDX_DEC;
      RS_OCT:    radix_cur = RDX_OCT;
      RS_PREFIX: radix_cur = prefix_radix;
      default:   radix_cur = radix_eff;
    endcase
  end

  assign digit   = digit_of(char_code);
  assign rv      = radix_value(radix_cur);
  assign run_ext = PROD_WIDTH'(run_eff);

  always_comb begin
    case (radix_cur)
      RDX_BIN: prod = run_ext << 1;
      RDX_OCT: prod = run_ext << 3;
      RDX_DEC: prod = (run_ext << 3) + (run_ext << 1);
      RDX_HEX: prod = run_ext << 4;
      default: prod = run_ext;
    endcase
  end

  assign sum   = prod + PROD_WIDTH'(digit);
  assign limit = (PROD_WIDTH'(1) << (VALUE_WIDTH - 1)) - PROD_WIDTH'(!neg_eff);

  assign sts.is_minus  = (char_code == CH_MINUS);
  assign sts.is_plus   = (char_code == CH_PLUS);
  assign sts.is_zero   = (char_code == CH_0);
  assign sts.is_prefix = is_prefix;
  assign sts.digit_ok  = (digit < {1'b0, rv});
  assign sts.overflow  = (sum > limit);
  assign sts.dcnt_zero = (dcnt_eff == '0);

  always_comb begin
    neg_nxt   = cmd.set_neg ? 1'b1 : neg_eff;
    radix_nxt = radix_cur;
    run_nxt   = cmd.digit_upd ? sum[VALUE_WIDTH-1:0] : run_eff;
    case (cmd.dcnt_op)
      DC_KEEP:  dcnt_nxt = dcnt_eff;
      DC_ONE:   dcnt_nxt = COUNT_WIDTH'(1);
      DC_CLEAR: dcnt_nxt = '0;
      DC_INC:   dcnt_nxt = (dcnt_eff == '1) ? dcnt_eff : dcnt_eff + COUNT_WIDTH'(1);
      default:  dcnt_nxt = dcnt_eff;
    endcase
    ccnt_nxt = (cmd.accept && (ccnt_eff != '1)) ? ccnt_eff + COUNT_WIDTH'(1) : ccnt_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r   <= 1'b0;
      radix_r <= RDX_DEC;
      run_r   <= '0;
      dcnt_r  <= '0;
      ccnt_r  <= '0;
    end else if (cmd.step) begin
      neg_r   <= neg_nxt;
      radix_r <= radix_nxt;
      run_r   <= run_nxt;
      dcnt_r  <= dcnt_nxt;
      ccnt_r  <= ccnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && cmd.emit) begin
      if (cmd.emit_status == ST_OK) begin
        value_r <= neg_nxt ? ({VALUE_WIDTH{1'b0}} - run_nxt) : run_nxt;
      end else begin
        value_r <= '0;
      end
      count_r  <= ccnt_nxt;
      status_r <= cmd.emit_status;
    end
  end

  assign res_value  = value_r;
  assign res_count  = count_r;
  assign res_status = status_r;

endmodule

// ===== src/ipl_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the integer literal parser: parse phase state machine,
// stream handshake and result pending flag. Depends on ipl_pkg.
module ipl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              first_char,
  input  logic              last_char,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  ipl_pkg::ipl_sts_t sts,
  output ipl_pkg::ipl_cmd_t cmd
);
  import ipl_pkg::*;

  phase_t  phase_r, phase_nxt, ph;
  logic    out_valid_r, out_valid_nxt;
  logic    fire, taken, digits_seen;
  status_t finish_status;

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;
  assign ph        = first_char ? PH_SIGN : phase_r;

  always_comb begin
    cmd             = '0;
    cmd.step        = fire;
    cmd.restart     = first_char;
    cmd.dcnt_op     = DC_KEEP;
    cmd.radix_op    = RS_KEEP;
    cmd.emit_status = ST_OK;
    taken           = 1'b0;
    phase_nxt       = ph;

    if (ph != PH_DONE) begin
      if (phase_nxt == PH_SIGN) begin
        phase_nxt = PH_RADIX;
        if (sts.is_minus) begin
          cmd.set_neg = 1'b1;
          cmd.accept  = 1'b1;
          taken       = 1'b1;
        end else if (sts.is_plus) begin
          cmd.accept = 1'b1;
          taken      = 1'b1;
        end
      end
      if (!taken && (phase_nxt == PH_RADIX)) begin
        if (sts.is_zero) begin
          cmd.accept  = 1'b1;
          cmd.dcnt_op = DC_ONE;
          phase_nxt   = PH_ZERO;
          taken       = 1'b1;
        end else begin
          cmd.radix_op = RS_DEC;
          phase_nxt    = PH_DIGITS;
        end
      end
      if (!taken && (phase_nxt == PH_ZERO)) begin
        phase_nxt = PH_DIGITS;
        if (sts.is_prefix) begin
          cmd.radix_op = RS_PREFIX;
          cmd.dcnt_op  = DC_CLEAR;
          cmd.accept   = 1'b1;
          taken        = 1'b1;
        end else begin
          cmd.radix_op = RS_OCT;
        end
      end
      if (!taken && (phase_nxt == PH_DIGITS)) begin
        if (sts.digit_ok) begin
          if (sts.overflow) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_OVERFLOW;
          end else begin
            cmd.digit_upd = 1'b1;
            cmd.dcnt_op   = DC_INC;
            cmd.accept    = 1'b1;
          end
        end else begin
          cmd.emit = 1'b1;
        end
      end
      if (!cmd.emit && last_char) begin
        cmd.emit = 1'b1;
      end
      if (cmd.emit) begin
        phase_nxt = PH_DONE;
        if (cmd.emit_status != ST_OVERFLOW) begin
          cmd.emit_status = finish_status;
        end
      end
    end
  end

  always_comb begin
    case (cmd.dcnt_op)
      DC_ONE:   digits_seen = 1'b1;
      DC_INC:   digits_seen = 1'b1;
      DC_CLEAR: digits_seen = 1'b0;
      default:  digits_seen = !sts.dcnt_zero;
    endcase
    finish_status = digits_seen ? ST_OK : ST_NO_DIGITS;
  end

  always_comb begin
    if (fire && cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIGN;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== src/integer_literal_parser.sv =====
`timescale 1ns / 1ps
// Top level of the signed integer literal parser with radix prefix.
// Joins ipl_ctrl and ipl_datapath; depends on ipl_pkg.
//
//   Channel | Direction | Carries
//   in_     | slave     | one text character, first mark in tuser, last mark in tlast
//   out_    | master    | parsed value and accepted count in tdata, status in tuser
//
// One character is taken per cycle while in_tready is high; the next one follows at once.
// The figure is set by the combinational multiply-add and limit compare.
// A result lands in the output register on the cycle its character is taken.
// in_tready drops only while a result waits and out_tready is low.
// Synchronous active-low reset restarts the parse and empties the output.
module integer_literal_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,  // char_code
  input  logic [0:0]                       in_tuser,  // first_char
  input  logic                             in_tlast,  // last_char
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ipl_pkg::OUT_DATA_W-1:0]   out_tdata, // value, accepted_count, zero fill
  output logic [1:0]                       out_tuser  // status
);
  import ipl_pkg::*;

  ipl_cmd_t                      cmd;
  ipl_sts_t                      sts;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic [COUNT_WIDTH-1:0]        res_count;

  ipl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .first_char (in_tuser[0]),
    .last_char  (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ipl_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_code  (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .res_value  (res_value),
    .res_count  (res_count),
    .res_status (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'({res_count, res_value});

endmodule
